@@ src/rhsl_pkg.sv @@
// rhsl_pkg: shared constants and types for the rgb to hsl converter
// no dependencies; imported by every module under src except rhsl_checker
`default_nettype none

package rhsl_pkg;

    // default configuration
    localparam int CHANNEL_BITS_DEF     = 8;
    localparam int HUE_SEXTANT_BITS_DEF = 8;

    // divider lanes
    localparam int LANE_HUE = 0;
    localparam int LANE_SAT = 1;
    localparam int LANE_NUM = 2;

    // sextant base codes, in sextants of a turn
    localparam logic [2:0] BASE_ONE   = 3'd1;
    localparam logic [2:0] BASE_THREE = 3'd3;
    localparam logic [2:0] BASE_FIVE  = 3'd5;
    localparam logic [2:0] BASE_TURN  = 3'd6;

    // hue control carried alongside the divider
    typedef struct packed {
        logic       grey;  // max equals min: hue and saturation forced to zero
        logic       neg;   // base minus ceil(quotient), else base plus floor(quotient)
        logic [2:0] base;  // sextant base code
    } hue_ctl_t;

endpackage

`default_nettype wire

@@ src/rhsl_front.sv @@
// rhsl_front: two pipeline stages, max/min and sextant pick, then divider operands
// depends on rhsl_pkg
`default_nettype none

module rhsl_front #(
    parameter int CB  = 8,
    parameter int HSB = 8,
    parameter int QW  = 9
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire logic [CB-1:0]        in_red,
    input  wire logic [CB-1:0]        in_green,
    input  wire logic [CB-1:0]        in_blue,
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output rhsl_pkg::hue_ctl_t        out_ctl,
    output logic [CB-1:0]             out_lightness,
    output logic [CB-1:0]             out_rem  [2],
    output logic [QW-1:0]             out_work [2],
    output logic [CB-1:0]             out_div  [2]
);
    import rhsl_pkg::*;

    localparam int NW = CB + QW;
    localparam logic [CB:0] FULL     = {1'b0, {CB{1'b1}}};
    localparam logic [CB:0] TWO_FULL = {{CB{1'b1}}, 1'b0};

    // stage 1
    logic            v1_reg;
    logic            ready2;
    logic [CB-1:0]   mx_next, mn_next, x_next;
    logic [CB-1:0]   mx_reg, mn_reg, x_reg;
    hue_ctl_t        ctl1_next, ctl1_reg;
    logic            v1_next;

    // stage 2
    logic            v2_reg, v2_next;
    logic [CB-1:0]   d;
    logic [CB:0]     sum;
    logic [CB-1:0]   num;
    logic [CB-1:0]   den;
    logic [CB:0]     den_hi;
    logic [2*CB-1:0] sat_n;
    logic [NW-1:0]   sat_ext, hue_ext;
    logic [CB-1:0]   rem_next  [2];
    logic [QW-1:0]   work_next [2];
    logic [CB-1:0]   div_next  [2];
    logic [CB-1:0]   rem_reg   [2];
    logic [QW-1:0]   work_reg  [2];
    logic [CB-1:0]   div_reg   [2];
    logic [CB-1:0]   light_reg;
    hue_ctl_t        ctl2_reg;

    assign ready2   = !v2_reg || out_ready;
    assign in_ready = !v1_reg || ready2;

    always_comb begin
        logic [CB-1:0] hi_rg, lo_rg;
        hi_rg   = (in_red > in_green) ? in_red : in_green;
        lo_rg   = (in_red < in_green) ? in_red : in_green;
        mx_next = (hi_rg > in_blue) ? hi_rg : in_blue;
        mn_next = (lo_rg < in_blue) ? lo_rg : in_blue;
        ctl1_next.grey = (mx_next == mn_next);
        // red first, then green, then blue
        if (in_red == mx_next) begin
            ctl1_next.neg  = (in_green != mn_next);
            ctl1_next.base = (in_green == mn_next) ? BASE_FIVE : BASE_ONE;
            x_next         = (in_green == mn_next) ? in_blue : in_green;
        end else if (in_green == mx_next) begin
            ctl1_next.neg  = (in_blue != mn_next);
            ctl1_next.base = (in_blue == mn_next) ? BASE_ONE : BASE_THREE;
            x_next         = (in_blue == mn_next) ? in_red : in_blue;
        end else begin
            ctl1_next.neg  = (in_red != mn_next);
            ctl1_next.base = (in_red == mn_next) ? BASE_THREE : BASE_FIVE;
            x_next         = (in_red == mn_next) ? in_green : in_red;
        end
        v1_next = in_ready ? in_valid : v1_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else begin
            v1_reg <= v1_next;
        end
        if (in_ready) begin
            mx_reg   <= mx_next;
            mn_reg   <= mn_next;
            x_reg    <= x_next;
            ctl1_reg <= ctl1_next;
        end
    end

    // operands: full*d over the lightness-side denominator, sext*(max-x) over d
    always_comb begin
        d       = mx_reg - mn_reg;
        sum     = {1'b0, mx_reg} + {1'b0, mn_reg};
        num     = mx_reg - x_reg;
        den_hi  = TWO_FULL - sum;
        den     = (sum <= FULL) ? sum[CB-1:0] : den_hi[CB-1:0];
        sat_n   = {d, {CB{1'b0}}} - {{CB{1'b0}}, d};
        sat_ext = NW'(sat_n);
        hue_ext = NW'({num, {HSB{1'b0}}});
        rem_next[LANE_HUE]  = hue_ext[NW-1:QW];
        work_next[LANE_HUE] = hue_ext[QW-1:0];
        div_next[LANE_HUE]  = d;
        rem_next[LANE_SAT]  = sat_ext[NW-1:QW];
        work_next[LANE_SAT] = sat_ext[QW-1:0];
        div_next[LANE_SAT]  = den;
        v2_next = ready2 ? v1_reg : v2_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else begin
            v2_reg <= v2_next;
        end
        if (ready2) begin
            rem_reg   <= rem_next;
            work_reg  <= work_next;
            div_reg   <= div_next;
            light_reg <= sum[CB:1];
            ctl2_reg  <= ctl1_reg;
        end
    end

    assign out_valid     = v2_reg;
    assign out_ctl       = ctl2_reg;
    assign out_lightness = light_reg;
    assign out_rem       = rem_reg;
    assign out_work      = work_reg;
    assign out_div       = div_reg;

endmodule

`default_nettype wire

@@ src/rhsl_div_stage.sv @@
// rhsl_div_stage: one restoring division step for the hue and saturation lanes
// depends on rhsl_pkg; instantiated once per quotient bit
`default_nettype none

module rhsl_div_stage #(
    parameter int CB = 8,
    parameter int QW = 9
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire rhsl_pkg::hue_ctl_t   in_ctl,
    input  wire logic [CB-1:0]        in_lightness,
    input  wire logic [CB-1:0]        in_rem  [2],
    input  wire logic [QW-1:0]        in_work [2],
    input  wire logic [CB-1:0]        in_div  [2],
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output rhsl_pkg::hue_ctl_t        out_ctl,
    output logic [CB-1:0]             out_lightness,
    output logic [CB-1:0]             out_rem  [2],
    output logic [QW-1:0]             out_work [2],
    output logic [CB-1:0]             out_div  [2]
);
    import rhsl_pkg::*;

    logic          valid_reg, valid_next;
    logic [CB:0]   trial [2];
    logic [CB:0]   diff  [2];
    logic          ge    [2];
    logic [CB-1:0] rem_next  [2];
    logic [QW-1:0] work_next [2];
    logic [CB-1:0] rem_reg   [2];
    logic [QW-1:0] work_reg  [2];
    logic [CB-1:0] div_reg   [2];
    logic [CB-1:0] light_reg;
    hue_ctl_t      ctl_reg;

    assign in_ready = !valid_reg || out_ready;

    // work shifts the next dividend bit out at the top and the quotient bit in below
    always_comb begin
        for (int i = 0; i < LANE_NUM; i++) begin
            trial[i]     = {in_rem[i], in_work[i][QW-1]};
            diff[i]      = trial[i] - {1'b0, in_div[i]};
            ge[i]        = (trial[i] >= {1'b0, in_div[i]});
            rem_next[i]  = ge[i] ? diff[i][CB-1:0] : trial[i][CB-1:0];
            work_next[i] = {in_work[i][QW-2:0], ge[i]};
        end
        valid_next = in_ready ? in_valid : valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        if (in_ready) begin
            rem_reg   <= rem_next;
            work_reg  <= work_next;
            div_reg   <= in_div;
            light_reg <= in_lightness;
            ctl_reg   <= in_ctl;
        end
    end

    assign out_valid     = valid_reg;
    assign out_ctl       = ctl_reg;
    assign out_lightness = light_reg;
    assign out_rem       = rem_reg;
    assign out_work      = work_reg;
    assign out_div       = div_reg;

endmodule

`default_nettype wire

@@ src/rhsl_back.sv @@
// rhsl_back: hue assembly from sextant base and quotient, output register
// depends on rhsl_pkg
`default_nettype none

module rhsl_back #(
    parameter int CB  = 8,
    parameter int HSB = 8,
    parameter int QW  = 9
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 in_valid,
    output logic                      in_ready,
    input  wire rhsl_pkg::hue_ctl_t   in_ctl,
    input  wire logic [CB-1:0]        in_lightness,
    input  wire logic [CB-1:0]        in_hue_rem,
    input  wire logic [QW-1:0]        in_work [2],
    output logic                      out_valid,
    input  wire logic                 out_ready,
    output logic [HSB+2:0]            out_hue,
    output logic [CB-1:0]             out_saturation,
    output logic [CB-1:0]             out_lightness
);
    import rhsl_pkg::*;

    localparam int HW = HSB + 4;
    localparam logic [HW-1:0] TURN = {1'b0, BASE_TURN, {HSB{1'b0}}};

    logic            valid_reg, valid_next;
    logic [HW-1:0]   base_full, q, round_up, raw, wrapped;
    logic [HSB+2:0]  hue_next, hue_reg;
    logic [CB-1:0]   sat_next, sat_reg, light_reg;

    assign in_ready = !valid_reg || out_ready;

    always_comb begin
        base_full = {1'b0, in_ctl.base, {HSB{1'b0}}};
        q         = HW'(in_work[LANE_HUE][HSB:0]);
        round_up  = HW'(|in_hue_rem);
        raw       = in_ctl.neg ? (base_full - q - round_up) : (base_full + q);
        wrapped   = (raw >= TURN) ? (raw - TURN) : raw;
        hue_next  = in_ctl.grey ? '0 : wrapped[HSB+2:0];
        sat_next  = in_ctl.grey ? '0 : in_work[LANE_SAT][CB-1:0];
        valid_next = in_ready ? in_valid : valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        if (in_ready) begin
            hue_reg   <= hue_next;
            sat_reg   <= sat_next;
            light_reg <= in_lightness;
        end
    end

    assign out_valid      = valid_reg;
    assign out_hue        = hue_reg;
    assign out_saturation = sat_reg;
    assign out_lightness  = light_reg;

endmodule

`default_nettype wire

@@ src/rgb_to_hsl_converter.sv @@
// rgb_to_hsl_converter: top level, pixel stream in, hue/saturation/lightness stream out
// depends on rhsl_pkg, rhsl_front, rhsl_div_stage, rhsl_back
//
// usage
//   the slave side takes one rgb pixel per request; the master side gives one
//   hsl result per request, in the same order, one result for every pixel
//   hue is in 1/(6*2^HUE_SEXTANT_BITS) of a turn, saturation and lightness
//   are scaled so all ones means full
//   from the accepting edge to m_tvalid a pixel passes two operand stages,
//   one restoring divider step per quotient bit and one output register;
//   QW, the number of quotient bits, is the larger of CHANNEL_BITS and
//   HUE_SEXTANT_BITS + 1
//   throughput is one pixel per cycle while nothing stalls; both divisions
//   run side by side in the same pipelined divider, a step per stage
//   each stage holds while the stage after it is full and stalled, so a
//   stalled receiver fills the pipeline and s_tready drops only once every
//   stage holds a request; nothing is dropped or repeated
//   reset (aresetn low at a clock edge) empties every stage; s_tready is high
//   from the first cycle after reset
`default_nettype none

module rgb_to_hsl_converter #(
    parameter int CHANNEL_BITS     = rhsl_pkg::CHANNEL_BITS_DEF,
    parameter int HUE_SEXTANT_BITS = rhsl_pkg::HUE_SEXTANT_BITS_DEF
) (
    input  wire logic                                       aclk,
    input  wire logic                                       aresetn,
    input  wire logic                                       s_tvalid,
    output logic                                            s_tready,
    // red, green, blue, zero padding
    input  wire logic [((3*CHANNEL_BITS+7)/8)*8-1:0]        s_tdata,
    output logic                                            m_tvalid,
    input  wire logic                                       m_tready,
    // hue, saturation, lightness, zero padding
    output logic [((HUE_SEXTANT_BITS+3+2*CHANNEL_BITS+7)/8)*8-1:0] m_tdata
);
    import rhsl_pkg::*;

    localparam int CB    = CHANNEL_BITS;
    localparam int HSB   = HUE_SEXTANT_BITS;
    localparam int QW    = (CB > HSB + 1) ? CB : HSB + 1;
    localparam int OUT_W = ((HSB + 3 + 2 * CB + 7) / 8) * 8;

    // pipeline links: index 0 leaves the operand stages, index QW enters the output stage
    logic          valid_w [QW+1];
    logic          ready_w [QW+1];
    hue_ctl_t      ctl_w   [QW+1];
    logic [CB-1:0] light_w [QW+1];
    logic [CB-1:0] rem_w   [QW+1][2];
    logic [QW-1:0] work_w  [QW+1][2];
    logic [CB-1:0] div_w   [QW+1][2];

    logic [HSB+2:0] hue;
    logic [CB-1:0]  saturation;
    logic [CB-1:0]  lightness;

    // max/min, sextant choice, divider operands
    rhsl_front #(.CB(CB), .HSB(HSB), .QW(QW)) u_front (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .in_valid      (s_tvalid),
        .in_ready      (s_tready),
        .in_red        (s_tdata[CB-1:0]),
        .in_green      (s_tdata[2*CB-1:CB]),
        .in_blue       (s_tdata[3*CB-1:2*CB]),
        .out_valid     (valid_w[0]),
        .out_ready     (ready_w[0]),
        .out_ctl       (ctl_w[0]),
        .out_lightness (light_w[0]),
        .out_rem       (rem_w[0]),
        .out_work      (work_w[0]),
        .out_div       (div_w[0])
    );

    // one quotient bit per stage, msb first
    for (genvar k = 0; k < QW; k++) begin : g_div
        rhsl_div_stage #(.CB(CB), .QW(QW)) u_step (
            .aclk          (aclk),
            .aresetn       (aresetn),
            .in_valid      (valid_w[k]),
            .in_ready      (ready_w[k]),
            .in_ctl        (ctl_w[k]),
            .in_lightness  (light_w[k]),
            .in_rem        (rem_w[k]),
            .in_work       (work_w[k]),
            .in_div        (div_w[k]),
            .out_valid     (valid_w[k+1]),
            .out_ready     (ready_w[k+1]),
            .out_ctl       (ctl_w[k+1]),
            .out_lightness (light_w[k+1]),
            .out_rem       (rem_w[k+1]),
            .out_work      (work_w[k+1]),
            .out_div       (div_w[k+1])
        );
    end

    // hue assembly and output register
    rhsl_back #(.CB(CB), .HSB(HSB), .QW(QW)) u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .in_valid       (valid_w[QW]),
        .in_ready       (ready_w[QW]),
        .in_ctl         (ctl_w[QW]),
        .in_lightness   (light_w[QW]),
        .in_hue_rem     (rem_w[QW][LANE_HUE]),
        .in_work        (work_w[QW]),
        .out_valid      (m_tvalid),
        .out_ready      (m_tready),
        .out_hue        (hue),
        .out_saturation (saturation),
        .out_lightness  (lightness)
    );

    assign m_tdata = OUT_W'({lightness, saturation, hue});

endmodule

`default_nettype wire

@@ src/rhsl_checker.sv @@
// rhsl_checker: port-level assertions for rgb_to_hsl_converter, with its bind
// depends on rgb_to_hsl_converter being compiled first
`default_nettype none

module rhsl_checker #(
    parameter int CHANNEL_BITS     = 8,
    parameter int HUE_SEXTANT_BITS = 8
) (
    input wire logic                                                aclk,
    input wire logic                                                aresetn,
    input wire logic                                                s_tready,
    input wire logic                                                m_tvalid,
    input wire logic                                                m_tready,
    input wire logic [((HUE_SEXTANT_BITS+3+2*CHANNEL_BITS+7)/8)*8-1:0] m_tdata
);
    localparam int CB  = CHANNEL_BITS;
    localparam int HSB = HUE_SEXTANT_BITS;
    localparam logic [HSB+2:0] TURN = {3'd6, {HSB{1'b0}}};

    logic [HSB+2:0] hue;
    logic [CB-1:0]  saturation;

    assign hue        = m_tdata[HSB+2:0];
    assign saturation = m_tdata[HSB+2+CB:HSB+3];

    // reset empties the output stage
    a_reset_empty: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("m_tvalid high after reset");

    // an empty output stage means every stage can take a pixel
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("s_tready low with empty pipeline");

    // hue stays below one full turn, and zero saturation comes only with zero hue
    a_hue_grey: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (hue < TURN) && ((saturation != '0) || (hue == '0)))
        else $error("hue out of range or non-zero hue on grey");

    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid)
        else $error("m_tvalid dropped while stalled");

    a_hold_data: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> $stable(m_tdata))
        else $error("m_tdata changed while stalled");

endmodule

bind rgb_to_hsl_converter rhsl_checker #(
    .CHANNEL_BITS     (CHANNEL_BITS),
    .HUE_SEXTANT_BITS (HUE_SEXTANT_BITS)
) u_rhsl_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

@@ bench/tb_top.sv @@
// tb_top: self-checking bench for rgb_to_hsl_converter, a directed table then random pixels
// with random gaps on both sides. depends on rhsl_pkg and rgb_to_hsl_converter
`default_nettype none

module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import rhsl_pkg::*;

    // widths at the default configuration
    localparam int CH_BITS  = CHANNEL_BITS_DEF;
    localparam int HUE_BITS = HUE_SEXTANT_BITS_DEF;
    localparam int HUE_W    = HUE_BITS + 3;
    localparam int S_W      = ((3*CH_BITS+7)/8)*8;
    localparam int M_W      = ((HUE_W+2*CH_BITS+7)/8)*8;
    localparam int FULL     = (1 << CH_BITS) - 1;
    localparam int SEXT     = 1 << HUE_BITS;

    // pipeline depth: two operand stages, one divider step per quotient bit, output register
    localparam int QUOT_W       = (CH_BITS > HUE_BITS + 1) ? CH_BITS : HUE_BITS + 1;
    localparam int LATENCY      = QUOT_W + 3;
    localparam int DRAIN_CYCLES = LATENCY + 8;
    // cycles with no request moving on either side before the run is abandoned
    localparam int STALL_LIMIT  = 5000;
    localparam int RANDOM_PIXELS = 1080;
    localparam int N_DIRECTED    = 23;

    typedef struct packed {
        logic [HUE_W-1:0]   hue;
        logic [CH_BITS-1:0] sat;
        logic [CH_BITS-1:0] light;
    } hsl_t;

    // one row of the directed table; the result is typed in only where known is set
    typedef struct packed {
        logic [CH_BITS-1:0] red;
        logic [CH_BITS-1:0] green;
        logic [CH_BITS-1:0] blue;
        logic               known;
        hsl_t               want;
    } pixel_row_t;

    logic           aclk     = 1'b0;
    logic           aresetn  = 1'b0;
    logic           s_tvalid = 1'b0;
    logic           s_tready;
    // red, green, blue, zero padding
    logic [S_W-1:0] s_tdata  = '0;
    logic           m_tvalid;
    logic           m_tready = 1'b0;
    // hue, saturation, lightness, zero padding
    logic [M_W-1:0] m_tdata;

    hsl_t pending_hsl[$];
    hsl_t want_hsl;
    int   mismatches   = 0;
    int   results_seen = 0;
    int   pixels_sent  = 0;
    int   grey_pixels  = 0;
    int   idle_cycles  = 0;
    int   stall_left   = 0;
    // while set, neither side idles, so the pipeline runs back to back
    bit   steady       = 1'b0;

    pixel_row_t directed_rows [0:N_DIRECTED-1] = '{
        // black, white and greys: hue and saturation forced to zero
        '{8'd0,   8'd0,   8'd0,   1'b1, '{11'd0,    8'd0,   8'd0}},
        '{8'd255, 8'd255, 8'd255, 1'b1, '{11'd0,    8'd0,   8'd255}},
        '{8'd128, 8'd128, 8'd128, 1'b1, '{11'd0,    8'd0,   8'd128}},
        '{8'd1,   8'd1,   8'd1,   1'b1, '{11'd0,    8'd0,   8'd1}},
        // primaries and secondaries; pure red makes a full turn and wraps to zero
        '{8'd255, 8'd0,   8'd0,   1'b1, '{11'd0,    8'd255, 8'd127}},
        '{8'd0,   8'd255, 8'd0,   1'b1, '{11'd512,  8'd255, 8'd127}},
        '{8'd0,   8'd0,   8'd255, 1'b1, '{11'd1024, 8'd255, 8'd127}},
        '{8'd255, 8'd255, 8'd0,   1'b1, '{11'd256,  8'd255, 8'd127}},
        '{8'd0,   8'd255, 8'd255, 1'b1, '{11'd768,  8'd255, 8'd127}},
        '{8'd255, 8'd0,   8'd255, 1'b1, '{11'd1280, 8'd255, 8'd127}},
        // smallest spread at the dark and light ends, both wrap the turn
        '{8'd1,   8'd0,   8'd0,   1'b1, '{11'd0,    8'd255, 8'd0}},
        '{8'd255, 8'd254, 8'd254, 1'b1, '{11'd0,    8'd255, 8'd254}},
        // one row inside each sextant
        '{8'd255, 8'd128, 8'd0,   1'b0, '0},
        '{8'd128, 8'd255, 8'd0,   1'b0, '0},
        '{8'd0,   8'd255, 8'd128, 1'b0, '0},
        '{8'd0,   8'd128, 8'd255, 1'b0, '0},
        '{8'd128, 8'd0,   8'd255, 1'b0, '0},
        '{8'd255, 8'd0,   8'd128, 1'b0, '0},
        // ties for the largest channel, the red-first order decides
        '{8'd200, 8'd200, 8'd100, 1'b0, '0},
        '{8'd100, 8'd200, 8'd200, 1'b0, '0},
        '{8'd200, 8'd100, 8'd200, 1'b0, '0},
        // dark ramp and near-white
        '{8'd1,   8'd2,   8'd3,   1'b0, '0},
        '{8'd254, 8'd255, 8'd255, 1'b0, '0}
    };

    rgb_to_hsl_converter u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // hue, saturation and lightness of one pixel in exact integer arithmetic
    function automatic hsl_t predict_hsl(input logic [CH_BITS-1:0] r, g, b);
        int   red, green, blue;
        int   hi, lo, spread, sum, hue, sat;
        hsl_t res;
        red   = int'(r);
        green = int'(g);
        blue  = int'(b);
        hi = (red > green) ? red : green;
        hi = (hi > blue) ? hi : blue;
        lo = (red < green) ? red : green;
        lo = (lo < blue) ? lo : blue;
        spread = hi - lo;
        sum    = hi + lo;
        hue = 0;
        sat = 0;
        if (spread != 0) begin
            if (sum <= FULL)
                sat = (FULL * spread) / sum;
            else
                sat = (FULL * spread) / (2*FULL - sum);
            // falling edge of a sextant takes the ceiling, rising edge the floor
            if (red == hi) begin
                if (green == lo)
                    hue = int'(BASE_FIVE)*SEXT + (SEXT*(hi - blue)) / spread;
                else
                    hue = int'(BASE_ONE)*SEXT - (SEXT*(hi - green) + spread - 1) / spread;
            end else if (green == hi) begin
                if (blue == lo)
                    hue = int'(BASE_ONE)*SEXT + (SEXT*(hi - red)) / spread;
                else
                    hue = int'(BASE_THREE)*SEXT - (SEXT*(hi - blue) + spread - 1) / spread;
            end else begin
                if (red == lo)
                    hue = int'(BASE_THREE)*SEXT + (SEXT*(hi - green)) / spread;
                else
                    hue = int'(BASE_FIVE)*SEXT - (SEXT*(hi - red) + spread - 1) / spread;
            end
            if (hue >= int'(BASE_TURN)*SEXT)
                hue = hue - int'(BASE_TURN)*SEXT;
        end
        res.hue   = hue[HUE_W-1:0];
        res.sat   = sat[CH_BITS-1:0];
        res.light = sum[CH_BITS:1];
        return res;
    endfunction

    // idle length: mostly none, often short, now and then long
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (steady || roll < 60)
            return 0;
        if (roll < 95)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // random pixel shaped to hit greys, ties, extremes and tiny spreads
    function automatic logic [3*CH_BITS-1:0] random_pixel();
        logic [CH_BITS-1:0] ch [3];
        logic [CH_BITS-1:0] base;
        int                 roll, k, v;
        roll = $urandom_range(0, 99);
        for (k = 0; k < 3; k++)
            ch[k] = CH_BITS'($urandom_range(0, FULL));
        if (roll < 40) begin
            // plain uniform
        end else if (roll < 50) begin
            ch[1] = ch[0];
            ch[2] = ch[0];
        end else if (roll < 65) begin
            k = $urandom_range(0, 2);
            ch[(k+1)%3] = ch[k];
        end else if (roll < 80) begin
            for (k = 0; k < 3; k++) begin
                case ($urandom_range(0, 4))
                    0: ch[k] = '0;
                    1: ch[k] = CH_BITS'(1);
                    2: ch[k] = CH_BITS'(FULL - 1);
                    3: ch[k] = FULL[CH_BITS-1:0];
                    default: ;
                endcase
            end
        end else if (roll < 90) begin
            base = ch[0];
            for (k = 1; k < 3; k++) begin
                v = int'(base) + $urandom_range(0, 6) - 3;
                ch[k] = (v < 0) ? '0 : (v > FULL) ? FULL[CH_BITS-1:0] : v[CH_BITS-1:0];
            end
        end else begin
            k = $urandom_range(0, 2);
            ch[k] = ($urandom_range(0, 1) != 0) ? FULL[CH_BITS-1:0] : '0;
        end
        return {ch[2], ch[1], ch[0]};
    endfunction

    // offer one pixel and hold it until taken, then record what it must give
    task automatic send_pixel(input logic [CH_BITS-1:0] r, g, b, input hsl_t want);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata  <= {b, g, r};
        do @(posedge aclk); while (!s_tready);
        pending_hsl.push_back(want);
        pixels_sent++;
        if (r == g && g == b)
            grey_pixels++;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // hold the input back until the pipeline has handed over every result
    task automatic wait_empty();
        s_tvalid <= 1'b0;
        while (pending_hsl.size() != 0)
            @(posedge aclk);
    endtask

    // receiver back-pressure, same gap profile as the sender
    always @(posedge aclk) begin : receiver
        int gap;
        if (stall_left > 0) begin
            m_tready   <= 1'b0;
            stall_left <= stall_left - 1;
        end else begin
            gap        = pick_gap();
            m_tready   <= (gap == 0);
            stall_left <= (gap > 0) ? gap - 1 : 0;
        end
    end

    // compare every result with the oldest expectation, field by field
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready) begin
            results_seen++;
            if (pending_hsl.size() == 0) begin
                $error("result with no pixel waiting: tdata %h", m_tdata);
                mismatches++;
            end else begin
                want_hsl = pending_hsl.pop_front();
                if (m_tdata[HUE_W-1:0] !== want_hsl.hue) begin
                    $error("hue: expected %0d, got %0d", want_hsl.hue, m_tdata[HUE_W-1:0]);
                    mismatches++;
                end
                if (m_tdata[HUE_W +: CH_BITS] !== want_hsl.sat) begin
                    $error("saturation: expected %0d, got %0d",
                           want_hsl.sat, m_tdata[HUE_W +: CH_BITS]);
                    mismatches++;
                end
                if (m_tdata[HUE_W+CH_BITS +: CH_BITS] !== want_hsl.light) begin
                    $error("lightness: expected %0d, got %0d",
                           want_hsl.light, m_tdata[HUE_W+CH_BITS +: CH_BITS]);
                    mismatches++;
                end
                if ((m_tdata >> (HUE_W + 2*CH_BITS)) !== '0) begin
                    $error("padding: expected 0, got %h", m_tdata >> (HUE_W + 2*CH_BITS));
                    mismatches++;
                end
            end
        end
    end

    // watchdog on cycles where no request moves on either side
    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("timeout: no request moved for %0d cycles", STALL_LIMIT);
            $display("FAIL");
            $finish;
        end
    end

    initial begin : stimulus
        int                 i;
        logic [3*CH_BITS-1:0] px;
        hsl_t               want;

        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed table
        for (i = 0; i < N_DIRECTED; i++) begin
            if (directed_rows[i].known)
                want = directed_rows[i].want;
            else
                want = predict_hsl(directed_rows[i].red, directed_rows[i].green,
                                   directed_rows[i].blue);
            send_pixel(directed_rows[i].red, directed_rows[i].green,
                       directed_rows[i].blue, want);
        end
        wait_empty();

        // random pixels; every fourth block of 100 runs without idling
        for (i = 0; i < RANDOM_PIXELS; i++) begin
            steady <= ((i / 100) % 4 == 3);
            if (i == RANDOM_PIXELS / 2)
                wait_empty();
            px = random_pixel();
            send_pixel(px[CH_BITS-1:0], px[CH_BITS +: CH_BITS], px[2*CH_BITS +: CH_BITS],
                       predict_hsl(px[CH_BITS-1:0], px[CH_BITS +: CH_BITS],
                                   px[2*CH_BITS +: CH_BITS]));
        end
        s_tvalid <= 1'b0;
        steady   <= 1'b0;

        // drain, then watch a little longer for anything unasked for
        while (pending_hsl.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("sent %0d pixels (%0d from the directed table, %0d grey), checked %0d results",
                 pixels_sent, N_DIRECTED, grey_pixels, results_seen);
        $display("mismatching fields: %0d", mismatches);
        if (mismatches == 0 && pending_hsl.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

`default_nettype wire
